[hw/rtl/ttcb_pkg.sv]
// ----------------------------------------------------------------------------
// ttcb_pkg
// Shared types and codes of the text terminal character buffer: word
// fields, event codes, opcodes and the special character bytes.
// ----------------------------------------------------------------------------
package ttcb_pkg;

   localparam int EV_W   = 3;
   localparam int POS_W  = 5;
   localparam int CHAR_W = 8;

   typedef enum logic [EV_W-1:0] {
      EV_DROPPED = 3'd0,
      EV_WRITTEN = 3'd1,
      EV_NEWLINE = 3'd2,
      EV_SCROLL  = 3'd3,
      EV_RETURN  = 3'd4,
      EV_READ    = 3'd5
   } event_type;

   localparam logic OP_PUT  = 1'b0;
   localparam logic OP_READ = 1'b1;

   localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
   localparam logic [CHAR_W-1:0] CH_RETURN  = 8'd13;
   localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
   localparam logic [CHAR_W-1:0] CH_NULL    = 8'h00;

   typedef struct packed {
      event_type               event_res;
      logic [POS_W-1:0]        row;
      logic [POS_W-1:0]        col;
      logic [CHAR_W-1:0]       char_out;
   } rsp_type;

endpackage

[hw/rtl/text_terminal_char_buffer.sv]
// Put, return and newline words are registered in the result buffer after
// accept; reads first pass the registered RAM read.
// Throughput: 1 put word per cycle while the result buffer has room; a read
// blocks input in its read state; a newline that scrolls blocks input while
// the new last row is written with spaces, one RAM write per column.
// Reset: a clearing pass writes zero to all ROWS*COLUMNS cells, one per
// cycle, and no word is taken until it ends.
// ----------------------------------------------------------------------------
// text_terminal_char_buffer
// Character-cell terminal store with cursor, carriage return, newline and
// ring-offset scrolling; cells live in one synchronous RAM.
// ----------------------------------------------------------------------------
module text_terminal_char_buffer #(
   parameter int ROWS    = 21,
   parameter int COLUMNS = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_opcode,
   input  logic [ttcb_pkg::CHAR_W-1:0]  req_char_in,
   input  logic [ttcb_pkg::POS_W-1:0]   req_read_row,
   input  logic [ttcb_pkg::POS_W-1:0]   req_read_col,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [ttcb_pkg::EV_W-1:0]    rsp_event_res,
   output logic [ttcb_pkg::POS_W-1:0]   rsp_row,
   output logic [ttcb_pkg::POS_W-1:0]   rsp_col,
   output logic [ttcb_pkg::CHAR_W-1:0]  rsp_char_out
);

   localparam int DEPTH = ROWS * COLUMNS;
   localparam int AW    = $clog2(DEPTH);
   localparam int RW    = $clog2(ROWS);
   localparam int RW1   = RW + 1;
   localparam int CIW   = $clog2(COLUMNS);
   localparam int CCW   = $clog2(COLUMNS + 1);
   localparam int PosW  = ttcb_pkg::POS_W;

   typedef enum logic [3:0] {
      ST_CLEAR = 4'b0001,
      ST_IDLE  = 4'b0010,
      ST_READ  = 4'b0100,
      ST_FILL  = 4'b1000
   } state_type;

   state_type         state_ff, state_in;
   logic [AW-1:0]     cnt_ff, cnt_in;
   logic [AW-1:0]     fill_base_ff, fill_base_in;
   logic [CCW-1:0]    cur_col_ff, cur_col_in;
   logic [RW-1:0]     cur_row_ff, cur_row_in;
   logic [RW-1:0]     top_ff, top_in;
   logic [PosW-1:0]   rd_row_ff, rd_row_in;
   logic [PosW-1:0]   rd_col_ff, rd_col_in;
   logic              rd_ok_ff, rd_ok_in;

   logic                        req_fire;
   logic                        rd_ok;
   logic                        mem_we;
   logic [AW-1:0]               mem_waddr;
   logic [ttcb_pkg::CHAR_W-1:0] mem_wdata;
   logic                        mem_re;
   logic [AW-1:0]               mem_raddr;
   logic [ttcb_pkg::CHAR_W-1:0] mem_rdata;
   logic                        push;
   logic                        push_ready;
   ttcb_pkg::rsp_type           push_data;
   ttcb_pkg::rsp_type           out_data;

   // logical row to physical cell address through the ring offset
   function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] lrow,
                                               input logic [RW-1:0] top,
                                               input logic [CIW-1:0] col);
      logic [RW1-1:0] sum;
      sum = {1'b0, lrow} + {1'b0, top};
      if (sum >= RW1'(ROWS)) begin
         sum = sum - RW1'(ROWS);
      end
      return AW'(sum) * AW'(COLUMNS) + AW'(col);
   endfunction

   assign req_ready = (state_ff == ST_IDLE) && push_ready;
   assign req_fire  = req_valid && req_ready;
   assign rd_ok     = (32'(req_read_row) < ROWS) && (32'(req_read_col) < COLUMNS);
   assign mem_raddr = cell_addr(RW'(req_read_row), top_ff, CIW'(req_read_col));

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      fill_base_in = fill_base_ff;
      cur_col_in   = cur_col_ff;
      cur_row_in   = cur_row_ff;
      top_in       = top_ff;
      rd_row_in    = rd_row_ff;
      rd_col_in    = rd_col_ff;
      rd_ok_in     = rd_ok_ff;
      mem_we       = 1'b0;
      mem_waddr    = cell_addr(cur_row_ff, top_ff, CIW'(cur_col_ff));
      mem_wdata    = req_char_in;
      mem_re       = 1'b0;
      push         = 1'b0;
      push_data.event_res = ttcb_pkg::EV_DROPPED;
      push_data.row       = PosW'(cur_row_ff);
      push_data.col       = '0;
      push_data.char_out  = ttcb_pkg::CH_NULL;

      case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = cnt_ff;
            mem_wdata = ttcb_pkg::CH_NULL;
            if (cnt_ff == AW'(DEPTH - 1)) begin
               cnt_in   = '0;
               state_in = ST_IDLE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               if (req_opcode == ttcb_pkg::OP_READ) begin
                  mem_re    = 1'b1;
                  rd_row_in = req_read_row;
                  rd_col_in = req_read_col;
                  rd_ok_in  = rd_ok;
                  state_in  = ST_READ;
               end else begin
                  push = 1'b1;
                  case (req_char_in)
                     ttcb_pkg::CH_NEWLINE: begin
                        cur_col_in = '0;
                        if (cur_row_ff == RW'(ROWS - 1)) begin
                           // scroll: old top row becomes the new last row
                           top_in       = (top_ff == RW'(ROWS - 1)) ? '0 : top_ff + 1'b1;
                           fill_base_in = AW'(top_ff) * AW'(COLUMNS);
                           cnt_in       = '0;
                           state_in     = ST_FILL;
                           push_data.event_res = ttcb_pkg::EV_SCROLL;
                        end else begin
                           cur_row_in          = cur_row_ff + 1'b1;
                           push_data.event_res = ttcb_pkg::EV_NEWLINE;
                           push_data.row       = PosW'(cur_row_ff + 1'b1);
                        end
                     end
                     ttcb_pkg::CH_RETURN: begin
                        cur_col_in          = '0;
                        push_data.event_res = ttcb_pkg::EV_RETURN;
                     end
                     default: begin
                        if (cur_col_ff < CCW'(COLUMNS)) begin
                           mem_we              = 1'b1;
                           cur_col_in          = cur_col_ff + 1'b1;
                           push_data.event_res = ttcb_pkg::EV_WRITTEN;
                           push_data.col       = PosW'(cur_col_ff);
                           push_data.char_out  = req_char_in;
                        end
                     end
                  endcase
               end
            end
         end
         ST_READ: begin
            push                = 1'b1;
            push_data.event_res = ttcb_pkg::EV_READ;
            push_data.row       = rd_row_ff;
            push_data.col       = rd_col_ff;
            push_data.char_out  = rd_ok_ff ? mem_rdata : ttcb_pkg::CH_NULL;
            state_in            = ST_IDLE;
         end
         ST_FILL: begin
            mem_we    = 1'b1;
            mem_waddr = fill_base_ff + cnt_ff;
            mem_wdata = ttcb_pkg::CH_SPACE;
            if (cnt_ff == AW'(COLUMNS - 1)) begin
               cnt_in   = '0;
               state_in = ST_IDLE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         cnt_ff     <= '0;
         cur_col_ff <= '0;
         cur_row_ff <= '0;
         top_ff     <= '0;
      end else begin
         state_ff   <= state_in;
         cnt_ff     <= cnt_in;
         cur_col_ff <= cur_col_in;
         cur_row_ff <= cur_row_in;
         top_ff     <= top_in;
      end
      fill_base_ff <= fill_base_in;
      rd_row_ff    <= rd_row_in;
      rd_col_ff    <= rd_col_in;
      rd_ok_ff     <= rd_ok_in;
   end

   ttcb_ram #(
      .WIDTH (ttcb_pkg::CHAR_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .re    (mem_re),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   ttcb_rsp_buf u_rsp_buf (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (push_data),
      .push_ready (push_ready),
      .out_valid  (rsp_valid),
      .out_ready  (rsp_ready),
      .out_data   (out_data)
   );

   assign rsp_event_res = out_data.event_res;
   assign rsp_row       = out_data.row;
   assign rsp_col       = out_data.col;
   assign rsp_char_out  = out_data.char_out;

endmodule

[hw/rtl/ttcb_ram.sv]
// ----------------------------------------------------------------------------
// ttcb_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module ttcb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 672
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

[hw/rtl/ttcb_rsp_buf.sv]
// ----------------------------------------------------------------------------
// ttcb_rsp_buf
// Two-entry result buffer: an output register plus a skid entry, so the
// core can hand over a word while the previous one still waits.
// ----------------------------------------------------------------------------
module ttcb_rsp_buf (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  ttcb_pkg::rsp_type push_data,
   output logic              push_ready,
   output logic              out_valid,
   input  logic              out_ready,
   output ttcb_pkg::rsp_type out_data
);

   logic              out_valid_ff, out_valid_in;
   logic              hold_valid_ff, hold_valid_in;
   ttcb_pkg::rsp_type out_data_ff, out_data_in;
   ttcb_pkg::rsp_type hold_data_ff, hold_data_in;
   logic              pop;

   assign pop        = out_valid_ff & out_ready;
   assign push_ready = ~hold_valid_ff;

   always_comb begin
      out_valid_in  = out_valid_ff;
      hold_valid_in = hold_valid_ff;
      out_data_in   = out_data_ff;
      hold_data_in  = hold_data_ff;
      if (hold_valid_ff) begin
         if (pop) begin
            out_data_in   = hold_data_ff;
            hold_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!out_valid_ff || pop) begin
            out_data_in  = push_data;
            out_valid_in = 1'b1;
         end else begin
            hold_data_in  = push_data;
            hold_valid_in = 1'b1;
         end
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         hold_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         hold_valid_ff <= hold_valid_in;
      end
      out_data_ff  <= out_data_in;
      hold_data_ff <= hold_data_in;
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

endmodule

[hw/rtl/ttcb_checker.sv]
// ----------------------------------------------------------------------------
// ttcb_checker
// Port-level checks of the terminal buffer, bound to the top level.
// ----------------------------------------------------------------------------
module ttcb_checker #(
   parameter int ROWS = 21
) (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [ttcb_pkg::EV_W-1:0]    rsp_event_res,
   input logic [ttcb_pkg::POS_W-1:0]   rsp_row,
   input logic [ttcb_pkg::POS_W-1:0]   rsp_col,
   input logic [ttcb_pkg::CHAR_W-1:0]  rsp_char_out
);

   localparam int PosW = ttcb_pkg::POS_W;

   // reset starts the clearing pass: nothing out, nothing taken
   assert property (@(posedge clock) reset |=> !rsp_valid && !req_ready)
      else $error("ttcb: busy or output word after reset");

   // a stalled result word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_event_res) &&
         $stable(rsp_row) && $stable(rsp_col) && $stable(rsp_char_out))
      else $error("ttcb: stalled result word changed");

   // cursor events carry no cell
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_event_res == ttcb_pkg::EV_DROPPED ||
         rsp_event_res == ttcb_pkg::EV_NEWLINE ||
         rsp_event_res == ttcb_pkg::EV_SCROLL ||
         rsp_event_res == ttcb_pkg::EV_RETURN) |-> rsp_col == '0 && rsp_char_out == '0)
      else $error("ttcb: cursor event with cell data");

   // scrolling leaves the cursor on the last row
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_res == ttcb_pkg::EV_SCROLL |-> rsp_row == PosW'(ROWS - 1))
      else $error("ttcb: scroll not on last row");

   // a plain newline never lands on the first row
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_res == ttcb_pkg::EV_NEWLINE |-> rsp_row != '0)
      else $error("ttcb: newline landed on first row");

endmodule

bind text_terminal_char_buffer ttcb_checker #(.ROWS(ROWS)) u_ttcb_checker (.*);
